[design/bld_pkg.sv]
package bld_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] REG_THRESH = 2'd0;
    localparam logic [1:0] REG_CTRL   = 2'd1;
    localparam logic [1:0] REG_IE     = 2'd2;
    localparam logic [1:0] REG_SOLAR  = 2'd3;

    localparam int CPS_W    = 27;
    localparam int MV_W     = 13;
    localparam int CNT_W    = 32;
    localparam int IE_END   = 4;
    localparam int IE_LOW   = 5;

    localparam logic [CPS_W-1:0] CPS_RESET    = 27'd32768;
    localparam logic [MV_W-1:0]  SOLAR_MIN_MV = 13'd1000;
    localparam logic [2:0]       N_REPEAT     = 3'd7;
    localparam logic [2:0]       N_STOP       = 3'd0;

    localparam logic [MV_W-1:0] THRESH_MV [0:31] = '{
        13'd1100, 13'd1150, 13'd1200, 13'd1250, 13'd1300, 13'd1350, 13'd1400, 13'd1450,
        13'd1500, 13'd1600, 13'd1700, 13'd1800, 13'd1900, 13'd2000, 13'd2100, 13'd2200,
        13'd2300, 13'd2400, 13'd2500, 13'd2600, 13'd2700, 13'd2800, 13'd2900, 13'd3000,
        13'd3100, 13'd3200, 13'd3300, 13'd3400, 13'd3500, 13'd3600, 13'd3800, 13'd4000
    };

    typedef struct packed {
        logic [1:0]      operation;
        logic [1:0]      register_select;
        logic [7:0]      write_data;
        logic [MV_W-1:0] battery_mv;
        logic [MV_W-1:0] solar_mv;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       end_interrupt;
        logic       low_interrupt;
    } t_result;

    typedef struct packed {
        logic decide;
        logic low;
    } t_judge;

endpackage

[design/battery_level_detector_top.sv]
// Battery level detector with four byte registers (threshold index, control/status,
// interval and interrupt enables, solar indicator). Each input beat is a tick, a register
// read or a register write and carries the present battery and solar voltages; each beat
// yields exactly one result beat with the read byte and the two interrupt pulses. A beat
// passes an input register and then a result register before its result beat is offered,
// and a new input beat can be taken in every cycle while the output is not stalled.
// While a result beat is held by the output stall, the input register takes at most one
// more input beat and then the input stalls until the result beat leaves.
module battery_level_detector_top
    import bld_pkg::*;
#(
    parameter int TEST_TICKS = 131072,
    parameter int INIT_TICKS = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_operation,
    input  logic [1:0]       i_register_select,
    input  logic [7:0]       i_write_data,
    input  logic [MV_W-1:0]  i_battery_mv,
    input  logic [MV_W-1:0]  i_solar_mv,
    input  logic             i_cfg_we,
    input  logic [CPS_W-1:0] i_cfg_wdata,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_read_data,
    output logic             o_end_interrupt,
    output logic             o_low_interrupt
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_ready;
    logic    fire;
    t_result core_result;
    t_result out_result;

    assign in_item.operation       = i_operation;
    assign in_item.register_select = i_register_select;
    assign in_item.write_data      = i_write_data;
    assign in_item.battery_mv      = i_battery_mv;
    assign in_item.solar_mv        = i_solar_mv;

    assign fire = held_valid && out_ready;

    bld_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    bld_core #(
        .TEST_TICKS (TEST_TICKS),
        .INIT_TICKS (INIT_TICKS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_result    (core_result)
    );

    bld_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_result (core_result),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_read_data     = out_result.read_data;
    assign o_end_interrupt = out_result.end_interrupt;
    assign o_low_interrupt = out_result.low_interrupt;

endmodule

[design/bld_in_stage.sv]
module bld_in_stage
    import bld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[design/bld_judge.sv]
module bld_judge
    import bld_pkg::*;
#(
    parameter int TEST_TICKS = 131072,
    parameter int INIT_TICKS = 16384
) (
    input  logic [MV_W-1:0]  i_thresh_mv,
    input  logic [MV_W-1:0]  i_battery_mv,
    input  logic [CNT_W-1:0] i_tick,
    input  logic             i_mode,
    output t_judge           o_judge
);

    localparam int EW   = $clog2(TEST_TICKS + 1);
    localparam int PW   = EW + MV_W + 1;
    localparam int AW   = 20;
    localparam int SPAN = TEST_TICKS - INIT_TICKS;

    logic [AW-1:0]    v50;
    logic [AW-1:0]    t49;
    logic [AW-1:0]    t51;
    logic             below;
    logic             above;
    logic             rising;
    logic [MV_W:0]    gap;
    logic [EW-1:0]    elapsed;
    logic [PW-1:0]    lhs;
    logic [PW-1:0]    rhs;

    assign v50   = AW'(i_battery_mv) * AW'(50);
    assign t49   = AW'(i_thresh_mv) * AW'(49);
    assign t51   = AW'(i_thresh_mv) * AW'(51);
    assign below = v50 < t49;
    assign above = v50 > t51;

    assign rising = i_mode || (i_battery_mv > i_thresh_mv);
    assign gap    = rising ? (MV_W + 1)'(t51 - v50) : (MV_W + 1)'(v50 - t49);

    assign elapsed = EW'(i_tick - CNT_W'(INIT_TICKS));
    assign lhs     = PW'({i_thresh_mv, 1'b0}) * PW'(elapsed);
    assign rhs     = PW'(SPAN) * PW'(gap);

    assign o_judge.decide = below || above || (lhs >= rhs);
    assign o_judge.low    = below || (!above && !rising);

endmodule

[design/bld_core.sv]
module bld_core
    import bld_pkg::*;
#(
    parameter int TEST_TICKS = 131072,
    parameter int INIT_TICKS = 16384
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CPS_W-1:0] i_cfg_wdata,
    input  logic             i_fire,
    input  t_item            i_item,
    output t_result          o_result
);

    logic [CPS_W-1:0] r_cps;
    logic [4:0]       r_thr,     n_thr;
    logic             r_mode,    n_mode;
    logic             r_flag,    n_flag;
    logic             r_control, n_control;
    logic [5:0]       r_ie,      n_ie;
    logic [3:0]       r_solar,   n_solar;
    logic             r_running, n_running;
    logic [CNT_W-1:0] r_tc,      n_tc;
    logic             r_lmode,   n_lmode;
    logic             r_lrep,    n_lrep;
    logic [4:0]       r_lthr,    n_lthr;
    logic             r_taken,   n_taken;
    logic [CPS_W-1:0] r_delay,   n_delay;

    logic [CNT_W-1:0] tc_inc;
    t_judge           judge;
    logic [2:0]       interval;

    assign tc_inc   = r_tc + CNT_W'(1);
    assign interval = r_ie[2:0];

    bld_judge #(
        .TEST_TICKS (TEST_TICKS),
        .INIT_TICKS (INIT_TICKS)
    ) u_judge (
        .i_thresh_mv  (THRESH_MV[r_lthr]),
        .i_battery_mv (i_item.battery_mv),
        .i_tick       (tc_inc),
        .i_mode       (r_lmode),
        .o_judge      (judge)
    );

    always_comb begin
        n_thr     = r_thr;
        n_mode    = r_mode;
        n_flag    = r_flag;
        n_control = r_control;
        n_ie      = r_ie;
        n_solar   = r_solar;
        n_running = r_running;
        n_tc      = r_tc;
        n_lmode   = r_lmode;
        n_lrep    = r_lrep;
        n_lthr    = r_lthr;
        n_taken   = r_taken;
        n_delay   = r_delay;
        o_result  = '0;

        unique case (i_item.operation)
            OP_TICK: begin
                if (r_running) begin
                    n_tc = tc_inc;
                    if (tc_inc >= CNT_W'(TEST_TICKS)) begin
                        n_running = 1'b0;
                        if (interval == N_STOP) begin
                            o_result.end_interrupt = r_ie[IE_END];
                            n_control              = 1'b0;
                        end else if (r_lrep) begin
                            n_running = 1'b1;
                            n_lmode   = r_mode;
                            n_lrep    = (interval == N_REPEAT);
                            n_lthr    = r_thr;
                            n_taken   = 1'b0;
                            n_tc      = '0;
                        end else begin
                            o_result.end_interrupt = r_ie[IE_END];
                            n_tc                   = '0;
                            n_delay                = r_cps >> interval;
                        end
                    end else if (tc_inc >= CNT_W'(INIT_TICKS) && !r_taken && judge.decide) begin
                        n_flag                 = !judge.low;
                        n_taken                = 1'b1;
                        o_result.low_interrupt = judge.low && r_ie[IE_LOW];
                    end
                end else if (r_control) begin
                    n_tc = tc_inc;
                    if (tc_inc >= CNT_W'(r_delay)) begin
                        n_running = 1'b1;
                        n_lmode   = r_mode;
                        n_lrep    = (interval == N_REPEAT);
                        n_lthr    = r_thr;
                        n_taken   = 1'b0;
                        n_tc      = '0;
                    end
                end
            end
            OP_READ: begin
                unique case (i_item.register_select)
                    REG_THRESH: o_result.read_data = {3'b000, r_thr};
                    REG_CTRL:   o_result.read_data = {5'b00000, r_mode, r_flag, r_control};
                    REG_IE:     o_result.read_data = {2'b00, r_ie};
                    REG_SOLAR:  o_result.read_data =
                        {3'b000, (i_item.solar_mv >= SOLAR_MIN_MV), r_solar};
                    default:    o_result.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (i_item.register_select)
                    REG_THRESH: n_thr = i_item.write_data[4:0];
                    REG_CTRL: begin
                        n_mode = i_item.write_data[2];
                        if (i_item.write_data[0]) begin
                            n_control = 1'b1;
                            if (!r_running) begin
                                n_running = 1'b1;
                                n_lmode   = i_item.write_data[2];
                                n_lrep    = 1'b0;
                                n_lthr    = r_thr;
                                n_taken   = 1'b0;
                                n_tc      = '0;
                            end
                        end else begin
                            n_control = 1'b0;
                            n_running = 1'b0;
                        end
                    end
                    REG_IE:    n_ie = {i_item.write_data[5:4], 1'b0, i_item.write_data[2:0]};
                    REG_SOLAR: n_solar = i_item.write_data[3:0];
                    default:   n_solar = r_solar;
                endcase
            end
            default: o_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cps <= CPS_RESET;
        end else if (i_cfg_we) begin
            r_cps <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= '0;
            r_mode    <= 1'b0;
            r_flag    <= 1'b1;
            r_control <= 1'b0;
            r_ie      <= '0;
            r_solar   <= '0;
            r_running <= 1'b0;
            r_tc      <= '0;
            r_lmode   <= 1'b0;
            r_lrep    <= 1'b0;
            r_lthr    <= '0;
            r_taken   <= 1'b0;
            r_delay   <= '0;
        end else if (i_fire) begin
            r_thr     <= n_thr;
            r_mode    <= n_mode;
            r_flag    <= n_flag;
            r_control <= n_control;
            r_ie      <= n_ie;
            r_solar   <= n_solar;
            r_running <= n_running;
            r_tc      <= n_tc;
            r_lmode   <= n_lmode;
            r_lrep    <= n_lrep;
            r_lthr    <= n_lthr;
            r_taken   <= n_taken;
            r_delay   <= n_delay;
        end
    end

endmodule

[design/bld_out_stage.sv]
module bld_out_stage
    import bld_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        if (i_fire) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
